@@ design/partial_likelihood_combine_top_macros.svh @@
// Assertion helpers for the top-level design file.
`ifndef PARTIAL_LIKELIHOOD_COMBINE_TOP_MACROS_SVH
`define PARTIAL_LIKELIHOOD_COMBINE_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PLC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("plc: implication check failed");

// Next-cycle implication, checked outside reset.
`define PLC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("plc: next-cycle check failed");

`endif

@@ design/plc_pkg.sv @@
package plc_pkg;

  localparam int NumStates = 4;
  localparam int QW        = 16;
  localparam int CfgIdxW   = 2;
  localparam int RowW      = NumStates * QW;
  localparam int InDataW   = 2 * RowW;
  localparam int OutDataW  = RowW;

  localparam logic [QW-1:0] QMax = '1;

  typedef logic [QW-1:0]               q_t;
  typedef q_t   [NumStates-1:0]        vec_t;

  // per-stage load enables handed to every lane
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

endpackage

@@ design/plc_lane.sv @@
module plc_lane (
  input  logic               clk_i,
  input  plc_pkg::stage_en_t en_i,
  input  plc_pkg::vec_t      q_row_i,
  input  plc_pkg::vec_t      left_i,
  input  plc_pkg::vec_t      right_i,
  output plc_pkg::q_t        res_o
);

  localparam int SumW = plc_pkg::QW + 2;

  plc_pkg::vec_t term_l_q, term_r_q;
  plc_pkg::q_t   sum_l_q, sum_r_q;
  plc_pkg::q_t   res_q;

  logic [2*plc_pkg::QW-1:0] prod_l [plc_pkg::NumStates];
  logic [2*plc_pkg::QW-1:0] prod_r [plc_pkg::NumStates];
  logic [SumW-1:0]          acc_l, acc_r;
  logic [2*plc_pkg::QW-1:0] prod_o;

  // stage 1: Q[s][j] * v[j], keep upper half
  always_comb begin
    for (int j = 0; j < plc_pkg::NumStates; j++) begin
      prod_l[j] = q_row_i[j] * left_i[j];
      prod_r[j] = q_row_i[j] * right_i[j];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      for (int j = 0; j < plc_pkg::NumStates; j++) begin
        term_l_q[j] <= prod_l[j][2*plc_pkg::QW-1:plc_pkg::QW];
        term_r_q[j] <= prod_r[j][2*plc_pkg::QW-1:plc_pkg::QW];
      end
    end
  end

  // stage 2: exact four-term sum, clamp to full scale
  always_comb begin
    acc_l = '0;
    acc_r = '0;
    for (int j = 0; j < plc_pkg::NumStates; j++) begin
      acc_l = acc_l + SumW'(term_l_q[j]);
      acc_r = acc_r + SumW'(term_r_q[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      sum_l_q <= (acc_l > SumW'(plc_pkg::QMax)) ? plc_pkg::QMax : acc_l[plc_pkg::QW-1:0];
      sum_r_q <= (acc_r > SumW'(plc_pkg::QMax)) ? plc_pkg::QMax : acc_r[plc_pkg::QW-1:0];
    end
  end

  // stage 3: product of both sums
  assign prod_o = sum_l_q * sum_r_q;

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      res_q <= prod_o[2*plc_pkg::QW-1:plc_pkg::QW];
    end
  end

  assign res_o = res_q;

endmodule

@@ design/plc_merge.sv @@
module plc_merge (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  plc_pkg::vec_t                   lane_res_i,
  input  logic                            valid_i,
  output logic                            load_o,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // out_a, out_c, out_g, out_t from bit 0 up
  output logic [plc_pkg::OutDataW-1:0]    m_axis_tdata
);

  logic          out_valid_q;
  plc_pkg::vec_t out_data_q;

  // output register frees when empty or taken this cycle
  assign load_o = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_o) begin
      out_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_o) begin
      out_data_q <= lane_res_i;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

@@ design/partial_likelihood_combine_top.sv @@
// Datapath: a result word reaches m_axis through four register stages
//   (products, clamped sums, final product, output register; the product
//   stage loads on the accepting edge itself).
// Throughput: one site word per cycle; each stage stalls only when the stage
//   after it is full, so bubbles are squeezed out under output back-pressure.
// Reset (rst_ni low, async): stage valids clear, matrix rows go to zero.
module partial_likelihood_combine_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // matrix row write port
  input  logic                            cfg_we_i,
  input  logic [plc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [plc_pkg::RowW-1:0]        cfg_wdata_i,
  // input site stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // left_a, left_c, left_g, left_t, right_a, right_c, right_g, right_t from bit 0 up
  input  logic [plc_pkg::InDataW-1:0]     s_axis_tdata,
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // out_a, out_c, out_g, out_t from bit 0 up
  output logic [plc_pkg::OutDataW-1:0]    m_axis_tdata
);

`include "partial_likelihood_combine_top_macros.svh"

  // transition matrix, one packed row per state
  plc_pkg::vec_t q_row_q [plc_pkg::NumStates];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < plc_pkg::NumStates; s++) begin
        q_row_q[s] <= '0;
      end
    end else if (cfg_we_i) begin
      q_row_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  // site fields
  plc_pkg::vec_t left_vec, right_vec;
  assign left_vec  = s_axis_tdata[plc_pkg::RowW-1:0];
  assign right_vec = s_axis_tdata[plc_pkg::InDataW-1:plc_pkg::RowW];

  // pipeline occupancy; the lanes carry payload only
  logic               v1_q, v2_q, v3_q;
  logic               out_load;
  plc_pkg::stage_en_t stage_en;

  // a stage may load when it is empty or its contents move on this cycle
  always_comb begin
    stage_en.s3 = !v3_q || out_load;
    stage_en.s2 = !v2_q || stage_en.s3;
    stage_en.s1 = !v1_q || stage_en.s2;
  end

  assign s_axis_tready = stage_en.s1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (stage_en.s1) begin
        v1_q <= s_axis_tvalid;
      end
      if (stage_en.s2) begin
        v2_q <= v1_q;
      end
      if (stage_en.s3) begin
        v3_q <= v2_q;
      end
    end
  end

  // one lane per output state, all sharing the same site vectors
  plc_pkg::vec_t lane_res;

  for (genvar s = 0; s < plc_pkg::NumStates; s++) begin : g_lane
    plc_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (stage_en),
      .q_row_i (q_row_q[s]),
      .left_i  (left_vec),
      .right_i (right_vec),
      .res_o   (lane_res[s])
    );
  end

  // gather lane results into the output word
  plc_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .lane_res_i    (lane_res),
    .valid_i       (v3_q),
    .load_o        (out_load),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // input is refused only when every stage holds a word
  `PLC_ASSERT_IMP(a_full_when_stalled, !s_axis_tready, v1_q && v2_q && v3_q && m_axis_tvalid)
  // a held last stage keeps its lane results
  `PLC_ASSERT_NXT(a_lane_hold, v3_q && !stage_en.s3, $stable(lane_res))
  // taking the output with nothing behind it empties the output register
  `PLC_ASSERT_NXT(a_drain, m_axis_tvalid && m_axis_tready && !v3_q, !m_axis_tvalid)

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps

module tb;

  // pipeline depth from the head of the top level, plus margin
  localparam int PipeDepth = 4;
  localparam int DrainWait = PipeDepth + 4;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [plc_pkg::CfgIdxW-1:0]   cfg_idx_i;
  logic [plc_pkg::RowW-1:0]      cfg_wdata_i;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  // left_a, left_c, left_g, left_t, right_a, right_c, right_g, right_t from bit 0 up
  logic [plc_pkg::InDataW-1:0]   s_axis_tdata;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  // out_a, out_c, out_g, out_t from bit 0 up
  logic [plc_pkg::OutDataW-1:0]  m_axis_tdata;

  // shadow of the transition matrix; row s entry j sits in element j
  plc_pkg::vec_t  q_mat [plc_pkg::NumStates];
  // combined likelihoods still owed by the block, oldest first
  plc_pkg::vec_t  combined_q [$];
  int    errors;
  // both sides run without gaps while set
  bit    no_idle;
  // request for a long receiver hold-off, picked up by the receiver process
  int    rx_hold_req;

  string out_name [plc_pkg::NumStates] = '{"out_a", "out_c", "out_g", "out_t"};

  partial_likelihood_combine_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Q0.16 multiply, low 16 bits dropped
  function automatic plc_pkg::q_t q_mul(plc_pkg::q_t a, plc_pkg::q_t b);
    logic [2*plc_pkg::QW-1:0] p;
    p = a * b;
    return p[2*plc_pkg::QW-1:plc_pkg::QW];
  endfunction

  // one row of the matrix against one vector, clamped at full scale
  function automatic plc_pkg::q_t row_sum(int s, plc_pkg::vec_t v);
    logic [plc_pkg::QW+1:0] acc;
    acc = '0;
    for (int j = 0; j < plc_pkg::NumStates; j++) acc += q_mul(q_mat[s][j], v[j]);
    return (acc > plc_pkg::QMax) ? plc_pkg::QMax : acc[plc_pkg::QW-1:0];
  endfunction

  // per state: product of the two propagated sums
  function automatic plc_pkg::vec_t combine_site(plc_pkg::vec_t left, plc_pkg::vec_t right);
    plc_pkg::vec_t res;
    for (int s = 0; s < plc_pkg::NumStates; s++)
      res[s] = q_mul(row_sum(s, left), row_sum(s, right));
    return res;
  endfunction

  // gap length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(21, 60);
  endfunction

  // likelihood value with the edges weighted up
  function automatic plc_pkg::q_t rand_q();
    case ($urandom_range(7))
      0:       return '0;
      1:       return plc_pkg::QMax;
      2:       return plc_pkg::q_t'($urandom_range(0, 255));
      3:       return plc_pkg::q_t'($urandom_range(65280, 65535));
      default: return plc_pkg::q_t'($urandom);
    endcase
  endfunction

  function automatic plc_pkg::vec_t rand_vec();
    plc_pkg::vec_t v;
    for (int j = 0; j < plc_pkg::NumStates; j++) v[j] = rand_q();
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Matrix load: all four rows back to back, only while the pipe is empty.
  // ---------------------------------------------------------------------------
  task automatic load_matrix(plc_pkg::vec_t rows [plc_pkg::NumStates]);
    for (int s = 0; s < plc_pkg::NumStates; s++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= s[plc_pkg::CfgIdxW-1:0];
      cfg_wdata_i <= rows[s];
      @(posedge clk_i);
      q_mat[s] = rows[s];
    end
    cfg_we_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Site sender. tvalid stays high across back-to-back words; it drops only
  // when a gap follows, so there is one assignment per edge.
  // ---------------------------------------------------------------------------
  task automatic send_site(plc_pkg::vec_t left, plc_pkg::vec_t right);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {right, left};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    combined_q.push_back(combine_site(left, right));
  endtask

  // stop offering, wait for every owed word, then let the pipe settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (combined_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random tready stalls, plus the long hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin : rx_drive
    int hold_cnt;
    int stall_cnt;
    hold_cnt  = 0;
    stall_cnt = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req > 0) begin
        hold_cnt    = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_cnt == 0 && stall_cnt == 0 && $urandom_range(3) == 0) stall_cnt = idle_len();
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready <= 1'b0;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every accepted word against the oldest prediction.
  // ---------------------------------------------------------------------------
  initial begin : result_check
    plc_pkg::vec_t want;
    plc_pkg::vec_t got;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (combined_q.size() == 0) begin
          $error("result word %h with nothing pending", got);
          errors++;
        end else begin
          want = combined_q.pop_front();
          for (int s = 0; s < plc_pkg::NumStates; s++)
            if (got[s] !== want[s]) begin
              $error("%s: expected %0d, got %0d", out_name[s], want[s], got[s]);
              errors++;
            end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // matrix still at reset: everything collapses to zero
  task automatic test_unconfigured();
    plc_pkg::vec_t ones;
    ones = {plc_pkg::NumStates{plc_pkg::QMax}};
    send_site(ones, ones);
    send_site('0, ones);
    send_site(rand_vec(), rand_vec());
    drain();
  endtask

  // corner matrices against corner vectors
  task automatic test_directed();
    plc_pkg::vec_t rows [plc_pkg::NumStates];
    plc_pkg::vec_t ones;
    plc_pkg::vec_t hot;
    ones = {plc_pkg::NumStates{plc_pkg::QMax}};

    // full-scale matrix: every sum against an all-ones vector clamps
    for (int s = 0; s < plc_pkg::NumStates; s++) rows[s] = ones;
    load_matrix(rows);
    send_site('0, '0);
    send_site(ones, ones);
    send_site(ones, '0);
    drain();

    // near-identity: each state passes straight through, one-hot probes
    for (int s = 0; s < plc_pkg::NumStates; s++) begin
      rows[s]    = '0;
      rows[s][s] = plc_pkg::QMax;
    end
    load_matrix(rows);
    for (int s = 0; s < plc_pkg::NumStates; s++) begin
      hot    = '0;
      hot[s] = plc_pkg::QMax;
      send_site(hot, ones);
    end
    send_site({plc_pkg::NumStates{16'hAAAA}}, {plc_pkg::NumStates{16'h5555}});
    send_site({plc_pkg::NumStates{16'h5555}}, {plc_pkg::NumStates{16'hAAAA}});
    drain();

    // distinct entries in every slot, so a swapped row or column shows up
    for (int s = 0; s < plc_pkg::NumStates; s++)
      for (int j = 0; j < plc_pkg::NumStates; j++)
        rows[s][j] = plc_pkg::q_t'((s * plc_pkg::NumStates + j + 1) * 4096 - 1);
    load_matrix(rows);
    send_site(ones, ones);
    send_site({16'h0001, 16'h0100, 16'h1000, 16'h8000}, ones);
    send_site(rand_vec(), rand_vec());
    send_site(rand_vec(), rand_vec());
    drain();

    // back to all zero through the write port
    for (int s = 0; s < plc_pkg::NumStates; s++) rows[s] = '0;
    load_matrix(rows);
    send_site(ones, ones);
    drain();
  endtask

  // random sites over several matrix settings
  task automatic test_random();
    plc_pkg::vec_t rows [plc_pkg::NumStates];
    for (int p = 0; p < 6; p++) begin
      for (int s = 0; s < plc_pkg::NumStates; s++)
        for (int j = 0; j < plc_pkg::NumStates; j++)
          case (p)
            0:       rows[s][j] = plc_pkg::q_t'($urandom);
            1:       rows[s][j] = plc_pkg::q_t'($urandom_range(0, 16383)); // row sums below 1
            2:       rows[s][j] = plc_pkg::QMax;
            default: rows[s][j] = rand_q();
          endcase
      load_matrix(rows);
      no_idle = (p == 3);
      repeat (250) send_site(rand_vec(), rand_vec());
      drain();
      no_idle = 1'b0;
    end
  endtask

  // receiver holds off while the sender keeps pushing: pipe fills, input stalls
  task automatic test_backpressure();
    plc_pkg::vec_t rows [plc_pkg::NumStates];
    for (int s = 0; s < plc_pkg::NumStates; s++) rows[s] = rand_vec();
    load_matrix(rows);
    no_idle     = 1'b1;
    rx_hold_req = 300;
    repeat (40) send_site(rand_vec(), rand_vec());
    no_idle = 1'b0;
    drain();
  endtask

  initial begin : main_seq
    errors        = 0;
    no_idle       = 1'b0;
    rx_hold_req   = 0;
    for (int s = 0; s < plc_pkg::NumStates; s++) q_mat[s] = '0;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= '0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_unconfigured();
    test_directed();
    test_backpressure();
    test_random();

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // hang guard, several times the slowest legal run
  initial begin : watchdog
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/plc_pkg.sv
design/plc_lane.sv
design/plc_merge.sv
design/partial_likelihood_combine_top.sv
dv/tb.sv
